>>> design/ckmp_pkg.sv
// Shared types, constants and helper functions for the colour-key mask packer.
package ckmp_pkg;

  // Default opacity table depth
  localparam int TABLE_DEPTH_DEF = 256;

  // Field widths
  localparam int CODE_W  = 24;
  localparam int TLEN_W  = 9;
  localparam int MBPP_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int CFGI_W  = 2;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_KEY_COLOUR   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_TABLE_LENGTH = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_MASK_BPP     = 2'd2;

  // Reset value of the mask width register
  localparam logic [MBPP_W-1:0] MBPP_RESET = 4'd1;

  // Item action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Results that one pixel item causes: an optional data byte, then pads
  typedef struct packed {
    logic              has_data;
    logic [BYTE_W-1:0] data;
    logic [1:0]        pads;
  } plan_t;

  // log2 of the group width; unsupported widths act as one bit
  function automatic logic [1:0] grp_log2(input logic [MBPP_W-1:0] m);
    logic [1:0] lg;
    case (m)
      4'd2:    lg = 2'd1;
      4'd4:    lg = 2'd2;
      4'd8:    lg = 2'd3;
      default: lg = 2'd0;
    endcase
    return lg;
  endfunction

  // All-ones group of the given log2 width
  function automatic logic [BYTE_W-1:0] grp_mask(input logic [1:0] lg);
    logic [BYTE_W-1:0] mk;
    case (lg)
      2'd0:    mk = 8'h01;
      2'd1:    mk = 8'h03;
      2'd2:    mk = 8'h0F;
      default: mk = 8'hFF;
    endcase
    return mk;
  endfunction

endpackage

>>> design/ckmp_table.sv
// One-bit opacity table memory with a registered read port.
module ckmp_table
  import ckmp_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic                     wr_bit,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_bit_r
);

  logic mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

endmodule

>>> design/ckmp_pack.sv
// Input stage, opaque/transparent classification and mask bit packing.
module ckmp_pack
  import ckmp_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              action,
  input  logic [CODE_W-1:0] pixel_code,
  input  logic              row_last,
  input  logic              rd_bit,
  input  logic [CODE_W-1:0] key_colour,
  input  logic [TLEN_W-1:0] table_length,
  input  logic [MBPP_W-1:0] mask_bpp,
  output logic              plan_valid,
  output plan_t             plan,
  input  logic              plan_ready
);

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_action_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_row_last_r;

  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [2:0]        pib_r, pib_nxt;
  logic [1:0]        phase_r, phase_nxt;

  logic              opaque;
  logic [1:0]        lg;
  logic [5:0]        pos;
  logic [BYTE_W-1:0] acc_set;
  logic [3:0]        count;
  logic [6:0]        cnt_bits;
  logic              full;
  logic              has_data;
  logic [1:0]        phase_aft;
  logic              consume;

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (plan_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_action_r   <= action;
      s1_code_r     <= pixel_code;
      s1_row_last_r <= row_last;
    end
  end

  // Classification: key compare, or table lookup below the table length
  always_comb begin
    if (table_length == '0) begin
      opaque = (s1_code_r != key_colour);
    end else if ((s1_code_r >= CODE_W'(table_length)) ||
                 (s1_code_r >= CODE_W'(TABLE_DEPTH))) begin
      opaque = 1'b1;
    end else begin
      opaque = rd_bit;
    end
  end

  // Packing: set the group, then emit on a full byte or at row end
  always_comb begin
    lg        = grp_log2(mask_bpp);
    pos       = 6'(pib_r) << lg;
    acc_set   = acc_r;
    if (opaque && (pos[5:3] == 3'd0)) begin
      acc_set = acc_r | (grp_mask(lg) << pos[2:0]);
    end
    count     = 4'(pib_r) + 4'd1;
    cnt_bits  = 7'(count) << lg;
    full      = (cnt_bits[6:3] != 4'd0);
    has_data  = full || (s1_row_last_r && (count[2:0] != 3'd0));
    phase_aft = phase_r + 2'(has_data);

    plan.has_data = has_data && (s1_action_r == ACT_PIXEL);
    plan.data     = acc_set;
    plan.pads     = (s1_row_last_r && (s1_action_r == ACT_PIXEL)) ? 2'(-phase_aft) : 2'd0;

    acc_nxt   = has_data ? '0 : acc_set;
    pib_nxt   = has_data ? 3'd0 : count[2:0];
    phase_nxt = s1_row_last_r ? 2'd0 : phase_aft;
  end

  assign plan_valid = s1_valid_r;
  assign consume    = s1_valid_r && plan_ready && (s1_action_r == ACT_PIXEL);

  // Packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      pib_r   <= '0;
      phase_r <= '0;
    end else if (consume) begin
      acc_r   <= acc_nxt;
      pib_r   <= pib_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> design/ckmp_emit.sv
// Result sequencer: data byte then pad bytes, through an output register.
module ckmp_emit
  import ckmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              plan_valid,
  input  plan_t             plan,
  output logic              plan_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_mask_byte,
  output logic              out_is_pad,
  output logic              out_last
);

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              pad_r, pad_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic              out_free;
  logic              nonzero;
  logic              take;

  assign out_free   = !valid_r || !out_stall;
  assign nonzero    = plan.has_data || (plan.pads != 2'd0);
  assign plan_ready = !nonzero || ((pend_r == 2'd0) && out_free);
  assign take       = plan_valid && nonzero && (pend_r == 2'd0) && out_free;

  // Next output: pending pads first, then a new item's first result
  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    pad_nxt   = pad_r;
    last_nxt  = last_r;
    pend_nxt  = pend_r;
    if (out_free) begin
      if (pend_r != 2'd0) begin
        valid_nxt = 1'b1;
        byte_nxt  = '0;
        pad_nxt   = 1'b1;
        last_nxt  = (pend_r == 2'd1);
        pend_nxt  = pend_r - 2'd1;
      end else if (take) begin
        valid_nxt = 1'b1;
        if (plan.has_data) begin
          byte_nxt = plan.data;
          pad_nxt  = 1'b0;
          last_nxt = (plan.pads == 2'd0);
          pend_nxt = plan.pads;
        end else begin
          byte_nxt = '0;
          pad_nxt  = 1'b1;
          last_nxt = (plan.pads == 2'd1);
          pend_nxt = plan.pads - 2'd1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    pad_r  <= pad_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_mask_byte = byte_r;
  assign out_is_pad    = pad_r;
  assign out_last      = last_r;

endmodule

>>> design/color_key_mask_packer_core.sv
// An accepted item is registered, then its first mask byte in the output register.
// Throughput: one item per cycle while in_stall is low; a pixel item causes at most
// one data byte and a row end up to three pad bytes, one per cycle unless stalled.
// The one-bit table is read at input accept and used from its read register.
// Synchronous active-low reset initialises the valid flags, configuration registers
// and packing state; the opacity table is not cleared and reads undefined until written.
module color_key_mask_packer_core
  import ckmp_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [CODE_W-1:0] in_pixel_code,
  input  logic              in_row_last,
  input  logic [7:0]        in_entry_index,
  input  logic [7:0]        in_entry_alpha,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_mask_byte,
  output logic              out_is_pad,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CODE_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [CODE_W-1:0] key_colour_r;
  logic [TLEN_W-1:0] table_length_r;
  logic [MBPP_W-1:0] mask_bpp_r;

  logic  in_acc;
  logic  wr_en;
  logic  rd_bit;
  logic  plan_valid;
  logic  plan_ready;
  plan_t plan;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_colour_r   <= '0;
      table_length_r <= '0;
      mask_bpp_r     <= MBPP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_COLOUR:   key_colour_r   <= cfg_data;
        CFG_TABLE_LENGTH: table_length_r <= cfg_data[TLEN_W-1:0];
        CFG_MASK_BPP:     mask_bpp_r     <= cfg_data[MBPP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = plan_valid && !plan_ready;
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_action == ACT_WRITE) &&
                    ({1'b0, in_entry_index} < 9'(TABLE_DEPTH));

  ckmp_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (in_entry_index[AW-1:0]),
    .wr_bit   (in_entry_alpha != 8'd0),
    .rd_en    (in_acc),
    .rd_addr  (in_pixel_code[AW-1:0]),
    .rd_bit_r (rd_bit)
  );

  ckmp_pack #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_pack (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_acc),
    .action       (in_action),
    .pixel_code   (in_pixel_code),
    .row_last     (in_row_last),
    .rd_bit       (rd_bit),
    .key_colour   (key_colour_r),
    .table_length (table_length_r),
    .mask_bpp     (mask_bpp_r),
    .plan_valid   (plan_valid),
    .plan         (plan),
    .plan_ready   (plan_ready)
  );

  ckmp_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .plan_valid    (plan_valid),
    .plan          (plan),
    .plan_ready    (plan_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mask_byte (out_mask_byte),
    .out_is_pad    (out_is_pad),
    .out_last      (out_last)
  );

endmodule

>>> design/ckmp_checker.sv
// Port-level checks on the mask packer's result stream, bound to the top level.
module ckmp_checker
  import ckmp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_mask_byte,
  input logic              out_is_pad,
  input logic              out_last
);

  // A stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // Pad bytes carry no mask bits
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_pad |-> out_mask_byte == 8'd0)
    else $error("pad item with nonzero mask byte");

  // A run that goes on after a data byte goes on with pads, in the next cycle
  a_data_then_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_is_pad && !out_last |=> out_valid && out_is_pad)
    else $error("data item not followed by pad");

  // Pads of one run follow one another without gaps
  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_is_pad && !out_last |=> out_valid && out_is_pad)
    else $error("pad run broken");

endmodule

bind color_key_mask_packer_core ckmp_checker u_ckmp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_mask_byte (out_mask_byte),
  .out_is_pad    (out_is_pad),
  .out_last      (out_last)
);
